>>> rtl/keyframe_track_interpolator_unit_macros.svh
// assertion macros for the keyframe track interpolator
`ifndef KEYFRAME_TRACK_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define KTI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("kti check failed");
`define KTI_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("kti check failed");
`else
`define KTI_ASSERT(lbl, clk, rst_n, prop)
`define KTI_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

>>> rtl/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg
// shared types and codes of the keyframe track interpolator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package kti_pkg;
  localparam int unsigned TimeW   = 24;
  localparam int unsigned WeightW = 16;
  localparam int unsigned QueryW  = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0, OP_EVAL = 2'd1, OP_HINT_RST = 2'd2, OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_SKIP = 2'd1, ST_EMPTY = 2'd2, ST_FULL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_MOVE, S_INS_PUT,
    S_EV_LAST, S_EV_HINT, S_EV_SCAN, S_EV_K1, S_EV_K2, S_EV_START, S_EV_DIV, S_EV_FIN,
    S_OUT
  } state_e;

  // datapath commands
  typedef enum logic [3:0] {
    C_NONE, C_LATCH, C_RD_POS, C_RD_LAST, C_RD_HINT, C_RD_SCAN, C_RD_K1, C_RD_K2,
    C_CAP_LAST, C_CAP_HINT, C_SCAN_STEP, C_SHIFT, C_PUT, C_CAP_K1, C_DIV_START,
    C_FINISH
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctl_t;

  typedef struct packed {
    logic ins_done;   // insert position reached
    logic scan_done;  // search found k2 or ran out
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

>>> rtl/kti_if.sv
// ----------------------------------------------------------------------------
// kti_in_if / kti_out_if
// valid-ready channels of the keyframe track interpolator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface kti_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  track;
  logic [23:0] key_frame_time;
  logic signed [15:0] key_weight;
  logic [31:0] query_time;
  modport source (output valid, operation, track, key_frame_time, key_weight,
                  query_time, input ready);
  modport sink (input valid, operation, track, key_frame_time, key_weight,
                query_time, output ready);
endinterface

interface kti_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] weight;
  logic [1:0]  status;
  modport source (output valid, weight, status, input ready);
  modport sink (input valid, weight, status, output ready);
endinterface
`default_nettype wire

>>> rtl/kti_ram.sv
// ----------------------------------------------------------------------------
// kti_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kti_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> rtl/kti_div.sv
// ----------------------------------------------------------------------------
// kti_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kti_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o,
  output logic                 rem_nz_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d, trial;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; cnt_d = CntW'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o   = busy_q && (cnt_q == CntW'(1));
  assign quo_o    = quo_d;
  assign rem_nz_o = (rem_d != '0);
endmodule
`default_nettype wire

>>> rtl/kti_ctrl.sv
// ----------------------------------------------------------------------------
// kti_ctrl
// sequencer for insert and evaluate transactions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "keyframe_track_interpolator_unit_macros.svh"
module kti_ctrl import kti_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic do_insert_i,  // insert that has room
  input  wire logic do_eval_i,    // evaluate that is neither empty nor skipped
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o
);
  state_e state_q, state_d;
  logic   acc;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_INSERT && do_insert_i) state_d = S_INS_RD;
          else if (op_i == OP_EVAL && do_eval_i) state_d = S_EV_LAST;
          else state_d = S_OUT;
        end
      end
      S_INS_RD:   state_d = S_INS_CMP;
      S_INS_CMP:  state_d = sts_i.ins_done ? S_INS_PUT : S_INS_MOVE;
      S_INS_MOVE: state_d = S_INS_RD;
      S_INS_PUT:  state_d = S_OUT;
      S_EV_LAST:  state_d = S_EV_HINT;
      S_EV_HINT:  state_d = S_EV_SCAN;
      S_EV_SCAN:  state_d = sts_i.scan_done ? S_EV_K1 : S_EV_SCAN;
      S_EV_K1:    state_d = S_EV_K2;
      S_EV_K2:    state_d = S_EV_START;
      S_EV_START: state_d = S_EV_DIV;
      S_EV_DIV:   state_d = sts_i.div_done ? S_EV_FIN : S_EV_DIV;
      S_EV_FIN:   state_d = S_OUT;
      S_OUT:      if (out_ready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.cmd   = C_NONE;
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    unique case (state_q)
      S_IDLE:     if (in_valid_i) ctl_o.cmd = C_LATCH;
      S_INS_RD:   ctl_o.cmd = C_RD_POS;
      S_INS_CMP:  ctl_o.cmd = C_RD_POS;  // keep key pos-1 on the read port for the move
      S_INS_MOVE: ctl_o.cmd = C_SHIFT;
      S_INS_PUT:  ctl_o.cmd = C_PUT;
      S_EV_LAST:  ctl_o.cmd = C_RD_LAST;
      S_EV_HINT:  ctl_o.cmd = C_CAP_LAST;
      S_EV_SCAN:  ctl_o.cmd = C_SCAN_STEP;
      S_EV_K1:    ctl_o.cmd = C_RD_K2;
      S_EV_K2:    ctl_o.cmd = C_NONE;
      S_EV_START: ctl_o.cmd = C_DIV_START;
      S_EV_DIV:   ctl_o.cmd = C_NONE;
      S_EV_FIN:   ctl_o.cmd = C_FINISH;
      S_OUT:      ctl_o.cmd = C_NONE;
      default:    ctl_o.cmd = C_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  `KTI_ASSERT(a_acc_idle, clk_i, rst_ni, acc |-> state_q == S_IDLE)
  `KTI_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o)
  `KTI_ASSERT(a_no_mix, clk_i, rst_ni, !(in_ready_o && out_valid_o))
endmodule
`default_nettype wire

>>> rtl/kti_dp.sv
// ----------------------------------------------------------------------------
// kti_dp
// key storage, search, interpolation arithmetic and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kti_dp import kti_pkg::*; #(
  parameter int unsigned Tracks = 16,
  parameter int unsigned Keys   = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic null_skip_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [3:0]  track_i,
  input  wire logic [23:0] ktime_i,
  input  wire logic [15:0] kweight_i,
  input  wire logic [31:0] query_i,
  input  wire logic        acc_i,
  output logic             do_insert_o,
  output logic             do_eval_o,
  input  wire ctl_t        ctl_i,
  output sts_t             sts_o,
  output logic [15:0]      weight_o,
  output logic [1:0]       status_o
);
  localparam int unsigned TW = (Tracks > 1) ? $clog2(Tracks) : 1;
  localparam int unsigned KW = $clog2(Keys);
  localparam int unsigned CW = $clog2(Keys + 1);

  logic [CW-1:0] cnt_q [Tracks];
  logic [KW-1:0] hint_q [Tracks];
  logic [TW-1:0] tsel;
  logic          trk_ok;
  logic [CW-1:0] n_in;

  assign trk_ok = ({28'd0, track_i} < 32'(Tracks));
  assign tsel   = TW'(track_i);
  assign n_in   = trk_ok ? cnt_q[tsel] : '0;

  // key weight 0 in the single-entry case needs a read; weight of entry 0 kept in w0_q
  logic [15:0] w0_q [Tracks];

  assign do_insert_o = trk_ok && (n_in < CW'(Keys));
  assign do_eval_o   = trk_ok && (n_in != '0) &&
                       !(null_skip_i && n_in == CW'(1) && w0_q[tsel] == '0);

  // latched transaction
  logic [TW-1:0] t_q;
  logic [23:0] kt_q;
  logic [15:0] kw_q;
  logic [31:0] q_q;
  logic [CW-1:0] n_q;
  logic [KW-1:0] hint_use_q;

  // ram port
  logic          we;
  logic [KW-1:0] ka;
  logic [39:0]   wdat, rdat;
  kti_ram #(.Width(40), .Depth(Tracks * Keys)) u_ram (
    .clk_i, .we_i(we), .addr_i({t_q, ka}), .wdata_i(wdat), .rdata_o(rdat)
  );

  logic [KW-1:0] pos_q;        // insert position / scan index
  logic [31:0]   cur_q;
  logic          hi_q;         // scan upward from hint
  logic          first_q;      // first scan read pending
  logic [KW-1:0] k2_q, k1_q;
  logic [31:0]   tf_q;
  logic signed [15:0] wf_q;
  logic signed [16:0] dw_q;    // wt - wf
  logic [31:0]   dt_q, dc_q;
  logic          eq_q;
  logic          neg_q;
  logic [15:0]   weight_q;
  logic [1:0]    status_q;

  logic [31:0] rtime;
  assign rtime = {rdat[39:16], 8'd0};

  // insert position test: read of pos-1 valid in S_INS_CMP
  logic ins_stop;
  assign ins_stop = (pos_q == '0) || !(rdat[39:16] > kt_q);

  // scan: rdat holds the key at pos_q, next address issued one step ahead
  logic scan_hit, scan_end;
  logic [KW-1:0] scan_lim;
  assign scan_hit = (cur_q <= rtime);
  assign scan_lim = hi_q ? KW'(n_q - 1'b1) : hint_use_q;

  logic          dv_start, dv_done, dv_rnz;
  logic [47:0]   dv_num, dv_quo;
  logic [47:0]   prod;
  assign prod   = 48'(dc_q) * 48'(dw_q[16] ? -dw_q : dw_q);
  assign dv_num = prod;
  assign dv_start = (ctl_i.cmd == C_DIV_START);
  kti_div #(.NumW(48), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dt_q),
    .done_o(dv_done), .quo_o(dv_quo), .rem_nz_o(dv_rnz)
  );

  logic signed [49:0] res;
  logic [48:0] qmag;
  always_comb begin
    qmag = {1'b0, dv_quo} + ((neg_q && dv_rnz) ? 49'd1 : 49'd0);
    res  = neg_q ? (50'(signed'(wf_q)) - 50'(qmag)) : (50'(signed'(wf_q)) + 50'(qmag));
  end

  assign scan_end = scan_hit || (pos_q == scan_lim);
  assign sts_o.ins_done  = ins_stop;
  assign sts_o.scan_done = !first_q && scan_end;
  assign sts_o.div_done  = dv_done;

  // k2 found from current scan
  logic [KW-1:0] k2_now, k1_now;
  assign k2_now = scan_hit ? pos_q : '0;
  assign k1_now = (k2_now <= KW'(1)) ? '0 : k2_now - 1'b1;

  // ram address
  always_comb begin
    we = 1'b0; ka = pos_q; wdat = rdat;
    unique case (ctl_i.cmd)
      C_RD_POS:    ka = pos_q - 1'b1;
      C_SHIFT:     begin we = 1'b1; ka = pos_q; wdat = rdat; end
      C_PUT:       begin we = 1'b1; ka = pos_q; wdat = {kt_q, kw_q}; end
      C_RD_LAST:   ka = KW'(n_q - 1'b1);
      C_CAP_LAST:  ka = hint_use_q;
      C_SCAN_STEP: begin
        if (first_q) ka = (cur_q < rtime) ? '0 : hint_use_q;
        else if (scan_end) ka = k1_now;
        else ka = pos_q + 1'b1;
      end
      C_RD_K2:     ka = k2_q;
      default:     ka = pos_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.cmd)
      C_LATCH: begin
        t_q <= tsel; kt_q <= ktime_i; kw_q <= kweight_i;
        q_q <= query_i; n_q <= n_in;
        hint_use_q <= (trk_ok && {1'b0, hint_q[tsel]} < n_in) ? hint_q[tsel] : '0;
        pos_q <= KW'(n_in);
        weight_q <= '0;
        if (op_i == OP_INSERT)      status_q <= do_insert_o ? ST_OK : ST_FULL;
        else if (op_i == OP_EVAL)
          status_q <= !trk_ok || n_in == '0 ? ST_EMPTY : (do_eval_o ? ST_OK : ST_SKIP);
        else                        status_q <= ST_OK;
      end
      C_RD_POS: ;
      C_SHIFT: pos_q <= pos_q - 1'b1;
      C_CAP_LAST: begin
        cur_q <= (q_q < rtime) ? q_q : rtime;
        first_q <= 1'b1;
      end
      C_SCAN_STEP: begin
        if (first_q) begin
          first_q <= 1'b0;
          hi_q <= !(cur_q < rtime);
          pos_q <= (cur_q < rtime) ? '0 : hint_use_q;
        end else if (scan_end) begin
          k2_q <= k2_now;
          k1_q <= k1_now;
          pos_q <= k1_now;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      C_RD_K2: begin // rdat = key k1
        tf_q <= rtime; wf_q <= rdat[15:0];
      end
      default: ;
    endcase
    if (ctl_i.cmd == C_FINISH) begin
      if (eq_q) weight_q <= wf_q;
      else if (res > 50'sd32767) weight_q <= 16'h7fff;
      else if (res < -50'sd32768) weight_q <= 16'h8000;
      else weight_q <= res[15:0];
    end
  end

  // k2 data capture: key k2 arrives from the ram in the cycle after C_RD_K2
  logic k2_cap_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) k2_cap_q <= 1'b0;
    else         k2_cap_q <= (ctl_i.cmd == C_RD_K2);
  end
  always_ff @(posedge clk_i) begin
    if (k2_cap_q) begin
      eq_q  <= (rtime == tf_q);
      dt_q  <= rtime - tf_q;
      dc_q  <= cur_q - tf_q;
      dw_q  <= 17'(signed'(rdat[15:0])) - 17'(wf_q);
      neg_q <= (17'(signed'(rdat[15:0])) - 17'(wf_q)) < 0;
    end
  end

  // per-track counters and hints
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Tracks; i++) begin cnt_q[i] <= '0; hint_q[i] <= '0; end
    end else if (acc_i && op_i == OP_CLEAR) begin
      for (int i = 0; i < Tracks; i++) begin cnt_q[i] <= '0; hint_q[i] <= '0; end
    end else if (acc_i && op_i == OP_HINT_RST) begin
      for (int i = 0; i < Tracks; i++) hint_q[i] <= '0;
    end else if (ctl_i.cmd == C_PUT) begin
      cnt_q[t_q] <= n_q + 1'b1;
    end else if (ctl_i.cmd == C_FINISH) begin
      hint_q[t_q] <= k1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == C_PUT && pos_q == '0) w0_q[t_q] <= kw_q;
  end

  assign weight_o = weight_q;
  assign status_o = status_q;
endmodule
`default_nettype wire

>>> rtl/keyframe_track_interpolator_unit.sv
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_unit
// keyframe track store with piecewise linear evaluation
// ----------------------------------------------------------------------------
// usage:
//   in_if carries one transaction (operation, track, key time, key weight,
//   query time); out_if returns one (weight, status) per input transaction.
//   one transaction at a time: the next is taken after the result is taken.
//   insert: moves later keys up, then writes the new one; evaluate: a key
//   scan of up to KEYS_PER_TRACK reads from the search hint, then a shift
//   subtract divider. other operations and rejected inserts/evaluates
//   answer in the cycle after they are taken. a stalled receiver holds the
//   result; no new transaction is taken then. reset clears counts, hints
//   and the skip register; key memory needs none. null_skip_wdata_i is
//   written when null_skip_we_i is high; user keeps that to idle, unchecked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module keyframe_track_interpolator_unit import kti_pkg::*; #(
  parameter int unsigned TRACKS = 16,
  parameter int unsigned KEYS_PER_TRACK = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic null_skip_we_i,
  input  wire logic null_skip_wdata_i,
  kti_in_if.sink    in_if,
  kti_out_if.source out_if
);
  logic skip_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) skip_q <= 1'b0;
    else if (null_skip_we_i) skip_q <= null_skip_wdata_i;
  end

  ctl_t ctl;
  sts_t sts;
  logic do_ins, do_ev, rdy;

  kti_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(rdy),
    .op_i(in_if.operation), .do_insert_i(do_ins), .do_eval_i(do_ev),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .ctl_o(ctl)
  );
  assign in_if.ready = rdy;

  kti_dp #(.Tracks(TRACKS), .Keys(KEYS_PER_TRACK)) u_dp (
    .clk_i, .rst_ni, .null_skip_i(skip_q), .op_i(in_if.operation),
    .track_i(in_if.track), .ktime_i(in_if.key_frame_time),
    .kweight_i(in_if.key_weight), .query_i(in_if.query_time),
    .acc_i(in_if.valid && rdy), .do_insert_o(do_ins), .do_eval_o(do_ev),
    .ctl_i(ctl), .sts_o(sts), .weight_o(out_if.weight), .status_o(out_if.status)
  );
endmodule
`default_nettype wire

>>> dv/keyframe_track_interpolator_unit_tb.sv
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_unit_tb
// self-checking testbench: a behavioral track store predicts every result,
// directed corner items are followed by random insert/evaluate/hint-reset/clear traffic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module keyframe_track_interpolator_unit_tb;
  import kti_pkg::*;

  localparam int NTRK = 16;
  localparam int NKEY = 64;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    op_e                op;
    logic [3:0]         track;
    logic [23:0]        key_time;
    logic signed [15:0] key_weight;
    logic [31:0]        query;
  } key_op_t;

  typedef struct packed {
    logic signed [15:0] weight;
    status_e            status;
  } key_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  kti_in_if  in_bus ();
  kti_out_if out_bus ();

  keyframe_track_interpolator_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .null_skip_we_i   (cfg_we),
    .null_skip_wdata_i(cfg_wdata),
    .in_if            (in_bus),
    .out_if           (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the track store
  logic [23:0]        trk_time [NTRK][NKEY];
  logic signed [15:0] trk_wt   [NTRK][NKEY];
  int                 trk_cnt  [NTRK];
  int                 trk_hint [NTRK];
  logic               skip_en;

  key_op_t  pending_ops[$];
  key_res_t expected_res[$];
  int errors = 0;
  int n_in = 0, n_out = 0, n_eval_ok = 0, n_full = 0, n_skip = 0;
  int cyc = 0;
  logic calm;

  assign calm = (cyc >= 3000) && (cyc < 8000);

  function automatic logic signed [15:0] interpolate(int t, longint unsigned qt);
    int n, h, k1, k2, i;
    longint unsigned last_t, cur, tf, tt;
    longint wf, wt, num, den, r;
    n = trk_cnt[t];
    h = trk_hint[t];
    k2 = 0;
    last_t = longint'(trk_time[t][n-1]) << 8;
    cur = qt < last_t ? qt : last_t;
    if (h >= n) h = 0;
    if (cur >= (longint'(trk_time[t][h]) << 8)) begin
      for (i = h; i < n; i++)
        if (cur <= (longint'(trk_time[t][i]) << 8)) begin k2 = i; break; end
    end else begin
      for (i = 0; i <= h && i < n; i++)
        if (cur <= (longint'(trk_time[t][i]) << 8)) begin k2 = i; break; end
    end
    k1 = k2 <= 1 ? 0 : k2 - 1;
    trk_hint[t] = k1;
    tf = longint'(trk_time[t][k1]) << 8;
    tt = longint'(trk_time[t][k2]) << 8;
    wf = trk_wt[t][k1];
    wt = trk_wt[t][k2];
    if (tf == tt || cur < tf || tt < tf) return wf[15:0];
    num = (wt - wf) * longint'(cur - tf);
    den = longint'(tt - tf);
    r = wf + ((num >= 0) ? num / den : -((-num + den - 1) / den));
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic key_res_t track_store_step(key_op_t it);
    key_res_t r;
    int t, p, i;
    r.weight = '0;
    r.status = ST_OK;
    t = it.track;
    case (it.op)
      OP_INSERT: begin
        if (trk_cnt[t] >= NKEY) begin
          r.status = ST_FULL;
        end else begin
          p = trk_cnt[t];
          while (p > 0 && trk_time[t][p-1] > it.key_time) p--;
          for (i = trk_cnt[t]; i > p; i--) begin
            trk_time[t][i] = trk_time[t][i-1];
            trk_wt[t][i] = trk_wt[t][i-1];
          end
          trk_time[t][p] = it.key_time;
          trk_wt[t][p] = it.key_weight;
          trk_cnt[t]++;
        end
      end
      OP_EVAL: begin
        if (trk_cnt[t] == 0) r.status = ST_EMPTY;
        else if (skip_en && trk_cnt[t] == 1 && trk_wt[t][0] == 0) r.status = ST_SKIP;
        else r.weight = interpolate(t, it.query);
      end
      OP_HINT_RST: begin
        foreach (trk_hint[j]) trk_hint[j] = 0;
      end
      default: begin
        foreach (trk_hint[j]) begin
          trk_hint[j] = 0;
          trk_cnt[j] = 0;
        end
      end
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.operation <= OP_INSERT;
      in_bus.track <= '0;
      in_bus.key_frame_time <= '0;
      in_bus.key_weight <= '0;
      in_bus.query_time <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        key_op_t acc;
        acc.op = op_e'(in_bus.operation);
        acc.track = in_bus.track;
        acc.key_time = in_bus.key_frame_time;
        acc.key_weight = in_bus.key_weight;
        acc.query = in_bus.query_time;
        expected_res.push_back(track_store_step(acc));
        n_in++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_ops.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
          key_op_t nx;
          nx = pending_ops.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.operation <= nx.op;
          in_bus.track <= nx.track;
          in_bus.key_frame_time <= nx.key_time;
          in_bus.key_weight <= nx.key_weight;
          in_bus.query_time <= nx.query;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver with one long hold-off to back up the block
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (!hold_done && n_out == 120) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s at result %0d: got %0d expected %0d", what, n_out, got, want);
  endtask

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        key_res_t e;
        e = expected_res.pop_front();
        if (out_bus.status !== e.status)
          report_mismatch("status", int'(out_bus.status), int'(e.status));
        if (out_bus.weight !== e.weight)
          report_mismatch("weight", int'(out_bus.weight), int'(e.weight));
        if (e.status == ST_OK && e.weight != 0) n_eval_ok++;
        if (e.status == ST_FULL) n_full++;
        if (e.status == ST_SKIP) n_skip++;
      end
      n_out++;
    end
  end

  // watchdog on cycles without any transaction
  int quiet = 0;
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  function automatic key_op_t mk(op_e op, int t, int kt, int kw, longint unsigned q);
    key_op_t it;
    it.op = op;
    it.track = t[3:0];
    it.key_time = kt[23:0];
    it.key_weight = kw[15:0];
    it.query = q[31:0];
    return it;
  endfunction

  function automatic key_op_t rand_op(int trk_lo, int trk_hi);
    key_op_t it;
    int sel;
    sel = $urandom_range(99);
    it.op = sel < 46 ? OP_INSERT : sel < 94 ? OP_EVAL : sel < 98 ? OP_HINT_RST : OP_CLEAR;
    it.track = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                        : 4'($urandom_range(trk_hi, trk_lo));
    it.key_time = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(40));
    it.key_weight = ($urandom_range(2) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(8192) - 4096);
    it.query = ($urandom_range(6) == 0) ? $urandom : 32'($urandom_range(42 * 256));
    return it;
  endfunction

  task automatic drain_and_write(logic v);
    while (pending_ops.size() > 0 || in_bus.valid || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    skip_en = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    foreach (trk_cnt[j]) begin
      trk_cnt[j] = 0;
      trk_hint[j] = 0;
    end
    skip_en = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drain_and_write(1'b1);
    pending_ops.push_back(mk(OP_EVAL, 0, 0, 0, 0));
    pending_ops.push_back(mk(OP_INSERT, 0, 0, -32768, 0));
    pending_ops.push_back(mk(OP_INSERT, 0, 24'hFFFFFF, 32767, 0));
    pending_ops.push_back(mk(OP_EVAL, 0, 0, 0, 0));
    pending_ops.push_back(mk(OP_EVAL, 0, 0, 0, 32'hFFFFFFFF));
    pending_ops.push_back(mk(OP_EVAL, 0, 0, 0, 32'h7FFFFF80));
    pending_ops.push_back(mk(OP_INSERT, 2, 5, 0, 0));
    pending_ops.push_back(mk(OP_EVAL, 2, 0, 0, 1000));
    pending_ops.push_back(mk(OP_INSERT, 2, 5, 100, 0));   // equal key times
    pending_ops.push_back(mk(OP_EVAL, 2, 0, 0, 5 * 256));
    pending_ops.push_back(mk(OP_INSERT, 3, 20, -4096, 0));
    pending_ops.push_back(mk(OP_INSERT, 3, 10, 4096, 0)); // lands before
    pending_ops.push_back(mk(OP_INSERT, 3, 30, 77, 0));
    pending_ops.push_back(mk(OP_EVAL, 3, 0, 0, 15 * 256 + 3));
    pending_ops.push_back(mk(OP_EVAL, 3, 0, 0, 28 * 256 + 1));
    pending_ops.push_back(mk(OP_EVAL, 3, 0, 0, 2 * 256)); // below hint
    pending_ops.push_back(mk(OP_HINT_RST, 3, 0, 0, 0));
    pending_ops.push_back(mk(OP_EVAL, 3, 0, 0, 25 * 256));
    pending_ops.push_back(mk(OP_EVAL, 15, 0, 0, 0));
    pending_ops.push_back(mk(OP_CLEAR, 0, 0, 0, 0));
    pending_ops.push_back(mk(OP_EVAL, 3, 0, 0, 0));

    drain_and_write(1'b0);
    repeat (200) pending_ops.push_back(rand_op(0, 3));

    // fill one track past capacity, then evaluate across it
    drain_and_write(1'b1);
    pending_ops.push_back(mk(OP_CLEAR, 0, 0, 0, 0));
    for (int i = 0; i < NKEY + 3; i++) begin
      key_op_t it;
      it = rand_op(15, 15);
      it.op = OP_INSERT;
      it.track = 4'd15;
      pending_ops.push_back(it);
    end
    repeat (20) pending_ops.push_back(mk(OP_EVAL, 15, 0, 0,
                                         ($urandom_range(3) == 0) ? $urandom
                                         : $urandom_range(42 * 256)));
    repeat (110) pending_ops.push_back(rand_op(4, 7));

    drain_and_write(1'b0);
    repeat (30) pending_ops.push_back(rand_op(8, 9));

    while (pending_ops.size() > 0 || in_bus.valid || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("covered %0d transactions in, %0d out: %0d nonzero evaluations,",
             n_in, n_out, n_eval_ok);
    $display("%0d full-track inserts, %0d skipped null tracks", n_full, n_skip);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
